FILE: rtl/bqf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multichannel biquad filter.
// No dependencies.
package bqf_pkg;

    localparam int COEF_BITS  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CH_BITS    = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 3'd5;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } coef_set_t;

    // load enables for the two arithmetic stages
    typedef struct packed {
        logic en_mul;
        logic en_acc;
    } arith_en_t;

endpackage

FILE: rtl/bqf_hist_mem.sv
`timescale 1ns / 1ps
// Per-channel history memory: one write port, one registered read port.
// No dependencies.
module bqf_hist_mem #(
    parameter int DEPTH  = 8,
    parameter int IDX_W  = 3,
    parameter int DATA_W = 96
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] hist_ram [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_ram[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= hist_ram[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bqf_arith.sv
`timescale 1ns / 1ps
// Biquad arithmetic: five registered products, then a registered sum with
// rounding offset. Depends on bqf_pkg.
module bqf_arith
    import bqf_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 22,
    parameter int ACC_W          = SAMPLE_BITS + COEF_BITS + 3
) (
    input  logic                          aclk,
    input  arith_en_t                     en,
    input  coef_set_t                     coefs,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] x1,
    input  logic signed [SAMPLE_BITS-1:0] x2,
    input  logic signed [SAMPLE_BITS-1:0] y1,
    input  logic signed [SAMPLE_BITS-1:0] y2,
    output logic signed [ACC_W-1:0]       acc
);

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_b0_reg, prod_b1_reg, prod_b2_reg;
    logic signed [PROD_W-1:0] prod_a1_reg, prod_a2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_ff @(posedge aclk) begin
        if (en.en_mul) begin
            prod_b0_reg <= PROD_W'(x)  * PROD_W'(coefs.b0);
            prod_b1_reg <= PROD_W'(x1) * PROD_W'(coefs.b1);
            prod_b2_reg <= PROD_W'(x2) * PROD_W'(coefs.b2);
            prod_a1_reg <= PROD_W'(y1) * PROD_W'(coefs.a1);
            prod_a2_reg <= PROD_W'(y2) * PROD_W'(coefs.a2);
        end
    end

    always_comb begin
        acc_next = ACC_W'(prod_b0_reg) + ACC_W'(prod_b1_reg) + ACC_W'(prod_b2_reg)
                 - ACC_W'(prod_a1_reg) - ACC_W'(prod_a2_reg) + RND;
    end

    always_ff @(posedge aclk) begin
        if (en.en_acc) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: rtl/multichannel_biquad_filter.sv
`timescale 1ns / 1ps
// Top level of the multichannel direct form I biquad filter.
// Depends on bqf_pkg, bqf_hist_mem and bqf_arith.
//
// Filters interleaved audio words, one per clock, through a shared biquad
// whose per-channel history (x1, x2, y1, y2) lives in a small synchronous
// memory. An accepted word reaches the output register after history read at
// acceptance, then products, sum, and round and saturate (with history
// write-back).
// Throughput is one word per clock as long as the output is taken and a
// filtered word does not share its channel with a filtered word still in
// stages p1 to p3; such a word waits on s_ready until the earlier one has
// written its history back.
// Output is rounded half up and saturated to SAMPLE_BITS. restart clears the
// history of every channel before its own word is filtered. In bypass mode,
// and for channel numbers at or above MAX_CHANNELS, words pass unchanged and
// no history moves. Coefficients are Q2.22 (COEF_FRAC_BITS fraction bits),
// already divided by a0; the user writes them over the cfg port while idle,
// unchecked. Reset: coefs zero, bypass on, all history clear; no clearing pass.
module multichannel_biquad_filter
    import bqf_pkg::*;
#(
    parameter int MAX_CHANNELS   = 8,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic [CH_BITS-1:0]            s_channel,
    input  logic                          s_restart,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic [CH_BITS-1:0]            m_channel_out
);

    localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int HIST_W   = 4 * SAMPLE_BITS;
    localparam int ACC_W    = SAMPLE_BITS + COEF_BITS + 3;
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    coef_set_t coefs_reg;
    logic      bypass_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg  <= '0;
            bypass_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_B0:     coefs_reg.b0 <= cfg_wdata;
                REG_B1:     coefs_reg.b1 <= cfg_wdata;
                REG_B2:     coefs_reg.b2 <= cfg_wdata;
                REG_A1:     coefs_reg.a1 <= cfg_wdata;
                REG_A2:     coefs_reg.a2 <= cfg_wdata;
                REG_BYPASS: bypass_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control
    //   p1: history read data available, products formed
    //   p2: products held, sum formed
    //   p3: sum held, round/saturate, history write-back
    //   out: result register
    // Each stage moves when the one after it is empty or moving, so the
    // pipe keeps filling while a result waits on m_ready.
    // ---------------------------------------------------------------
    logic p1_valid_reg, p1_valid_next;
    logic p2_valid_reg, p2_valid_next;
    logic p3_valid_reg, p3_valid_next;
    logic out_valid_reg, out_valid_next;

    logic adv3, adv2, adv1;
    logic accept;
    logic new_filt;
    logic hazard;

    // payload carried along the pipe
    logic                          p1_filt_reg, p2_filt_reg, p3_filt_reg;
    logic                          p1_hvalid_reg;
    logic [CH_BITS-1:0]            p1_ch_reg, p2_ch_reg, p3_ch_reg;
    logic signed [SAMPLE_BITS-1:0] p1_x_reg, p2_x_reg, p3_x_reg;
    logic signed [SAMPLE_BITS-1:0] p2_x1_reg, p3_x1_reg;
    logic signed [SAMPLE_BITS-1:0] p2_y1_reg, p3_y1_reg;

    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [CH_BITS-1:0]            out_channel_reg;

    assign adv3 = !out_valid_reg || m_ready;
    assign adv2 = !p3_valid_reg || adv3;
    assign adv1 = !p2_valid_reg || adv2;

    assign new_filt = !bypass_reg && (32'(s_channel) < MAX_CHANNELS);

    // read-modify-write interlock on the history memory
    assign hazard = new_filt && (
        (p1_valid_reg && p1_filt_reg && (p1_ch_reg == s_channel)) ||
        (p2_valid_reg && p2_filt_reg && (p2_ch_reg == s_channel)) ||
        (p3_valid_reg && p3_filt_reg && (p3_ch_reg == s_channel)));

    assign s_ready = (!p1_valid_reg || adv1) && !hazard;
    assign accept  = s_valid && s_ready;

    always_comb begin
        p1_valid_next  = accept ? 1'b1 : (adv1 ? 1'b0 : p1_valid_reg);
        p2_valid_next  = adv1 ? p1_valid_reg : (adv2 ? 1'b0 : p2_valid_reg);
        p3_valid_next  = adv2 ? p2_valid_reg : (adv3 ? 1'b0 : p3_valid_reg);
        out_valid_next = adv3 ? p3_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            p3_valid_reg  <= p3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // History valid flags: a clear flag reads as zero history.
    // Updated at acceptance; the interlock keeps the matching memory
    // write ahead of any later read of that channel.
    // ---------------------------------------------------------------
    logic [MAX_CHANNELS-1:0] hvalid_reg, hvalid_next;
    logic [CH_IDX_W-1:0]     new_idx;

    assign new_idx = CH_IDX_W'(s_channel);

    always_comb begin
        hvalid_next = hvalid_reg;
        if (accept && new_filt) begin
            if (s_restart) begin
                hvalid_next = '0;
            end
            hvalid_next[new_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hvalid_reg <= '0;
        end else begin
            hvalid_reg <= hvalid_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage p1 capture
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_x_reg      <= s_sample_in;
            p1_ch_reg     <= s_channel;
            p1_filt_reg   <= new_filt;
            p1_hvalid_reg <= !s_restart && hvalid_reg[new_idx];
        end
    end

    // ---------------------------------------------------------------
    // History memory: {x1, x2, y1, y2}
    // ---------------------------------------------------------------
    logic [HIST_W-1:0]             rd_hist;
    logic [HIST_W-1:0]             wr_hist;
    logic                          mem_we;
    logic [CH_IDX_W-1:0]           wr_idx;
    logic signed [SAMPLE_BITS-1:0] h_x1, h_x2, h_y1, h_y2;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    assign mem_we = adv3 && p3_valid_reg && p3_filt_reg;
    assign wr_idx = CH_IDX_W'(p3_ch_reg);
    assign wr_hist = {p3_x_reg, p3_x1_reg, y_sat, p3_y1_reg};

    bqf_hist_mem #(
        .DEPTH  (MAX_CHANNELS),
        .IDX_W  (CH_IDX_W),
        .DATA_W (HIST_W)
    ) u_hist_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_idx  (wr_idx),
        .wr_data (wr_hist),
        .rd_en   (accept),
        .rd_idx  (new_idx),
        .rd_data (rd_hist)
    );

    // zero history where the channel flag was clear
    always_comb begin
        if (p1_hvalid_reg) begin
            h_x1 = rd_hist[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
            h_x2 = rd_hist[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
            h_y1 = rd_hist[2*SAMPLE_BITS-1:SAMPLE_BITS];
            h_y2 = rd_hist[SAMPLE_BITS-1:0];
        end else begin
            h_x1 = '0;
            h_x2 = '0;
            h_y1 = '0;
            h_y2 = '0;
        end
    end

    // ---------------------------------------------------------------
    // Arithmetic
    // ---------------------------------------------------------------
    arith_en_t               arith_en;
    logic signed [ACC_W-1:0] acc;

    assign arith_en.en_mul = adv1;
    assign arith_en.en_acc = adv2;

    bqf_arith #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .ACC_W          (ACC_W)
    ) u_arith (
        .aclk  (aclk),
        .en    (arith_en),
        .coefs (coefs_reg),
        .x     (p1_x_reg),
        .x1    (h_x1),
        .x2    (h_x2),
        .y1    (h_y1),
        .y2    (h_y2),
        .acc   (acc)
    );

    always_ff @(posedge aclk) begin
        if (adv1) begin
            p2_x_reg    <= p1_x_reg;
            p2_x1_reg   <= h_x1;
            p2_y1_reg   <= h_y1;
            p2_ch_reg   <= p1_ch_reg;
            p2_filt_reg <= p1_filt_reg;
        end
        if (adv2) begin
            p3_x_reg    <= p2_x_reg;
            p3_x1_reg   <= p2_x1_reg;
            p3_y1_reg   <= p2_y1_reg;
            p3_ch_reg   <= p2_ch_reg;
            p3_filt_reg <= p2_filt_reg;
        end
    end

    // ---------------------------------------------------------------
    // Round (offset already in acc), floor shift, saturate
    // ---------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_shr;

    always_comb begin
        acc_shr = acc >>> COEF_FRAC_BITS;
        if (acc_shr > SAT_HI) begin
            y_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (acc_shr < SAT_LO) begin
            y_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            y_sat = acc_shr[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3 && p3_valid_reg) begin
            out_sample_reg  <= p3_filt_reg ? y_sat : p3_x_reg;
            out_channel_reg <= p3_ch_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_sample_out  = out_sample_reg;
    assign m_channel_out = out_channel_reg;

`ifndef SYNTHESIS
    // no two filtered words of one channel in p1 and p2 together
    a_no_ch_overlap_12: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_filt_reg && p2_valid_reg && p2_filt_reg)
        |-> (p1_ch_reg != p2_ch_reg))
        else $error("two filtered words of one channel in p1 and p2");

    // history write-back never races a read of the same channel
    a_no_rmw_race: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && accept && new_filt) |-> (wr_idx != new_idx))
        else $error("history read and write-back hit the same channel");

    // restart leaves only the current channel's history flag set
    a_restart_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && new_filt && s_restart) |=> $onehot(hvalid_reg))
        else $error("history flags wrong after restart");
`endif

endmodule
